// ===== rtl/crs_pkg.sv =====
// shared types, codes and constants of the clock register write sequencer
`default_nettype none
package crs_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0]  PPS_ENABLE_WORD = 32'h0000_007D;
  localparam logic [TICKS_W-1:0] TIMEOUT_RESET   = 16'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REQ   = 2'd1,
    CMD_OK    = 2'd2,
    CMD_FAIL  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_HARD_SYNC = 3'd1,
    ACT_PPS       = 3'd2,
    ACT_INC       = 3'd3,
    ACT_ADJUST    = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    TGT_SEC    = 3'd0,
    TGT_NS     = 3'd1,
    TGT_PPS    = 3'd2,
    TGT_SUBINC = 3'd3,
    TGT_INC    = 3'd4,
    TGT_ADJ    = 3'd5
  } tgt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_EN = 1'd0,
    CFG_TIMEOUT  = 1'd1
  } cfg_idx_t;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_WR_SEC = 14'b00000000000010,
    ST_WT_SEC = 14'b00000000000100,
    ST_WR_NS  = 14'b00000000001000,
    ST_WT_NS  = 14'b00000000010000,
    ST_WR_PPS = 14'b00000000100000,
    ST_WT_PPS = 14'b00000001000000,
    ST_WR_SUB = 14'b00000010000000,
    ST_WT_SUB = 14'b00000100000000,
    ST_WR_INC = 14'b00001000000000,
    ST_WT_INC = 14'b00010000000000,
    ST_WR_ADJ = 14'b00100000000000,
    ST_WT_ADJ = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        action;
    logic [WORD_W-1:0] value_a;
    logic [WORD_W-1:0] value_b;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        target;
    logic [WORD_W-1:0] write_value;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_msg_t;

endpackage
`default_nettype wire

// ===== rtl/crs_if.sv =====
// valid/ready channel interfaces for request items and result items
`default_nettype none
interface crs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  action;
  logic [31:0] value_a;
  logic [31:0] value_b;

  modport source (output valid, output command, output action, output value_a,
                  output value_b, input ready);
  modport sink   (input valid, input command, input action, input value_a,
                  input value_b, output ready);
endinterface

interface crs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  target;
  logic [31:0] write_value;

  modport source (output valid, output kind, output target, output write_value,
                  input ready);
  modport sink   (input valid, input kind, input target, input write_value,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/crs_in_stage.sv =====
// input register holding one accepted transaction until the sequencer takes it
`default_nettype none
module crs_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire crs_pkg::item_t in_item,
  input  wire logic          take,
  output      logic          held_valid,
  output      crs_pkg::item_t held_item
);

  logic           v_r, v_nxt;
  crs_pkg::item_t item_r;

  assign in_ready   = !v_r || take;
  assign held_valid = v_r;
  assign held_item  = item_r;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (take) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crs_core.sv =====
// sequencer state, stored operand words, configuration and result decode
`default_nettype none
module crs_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [crs_pkg::TICKS_W-1:0]      cfg_data,
  input  wire logic                             fire,
  input  wire crs_pkg::item_t                   item,
  output      crs_pkg::res_msg_t                res
);

  crs_pkg::state_t               state_r, state_nxt;
  logic [2:0]                    pend_r, pend_nxt;
  logic                          done_r, done_nxt;
  logic [crs_pkg::TICKS_W-1:0]   cnt_r, cnt_nxt;
  logic [crs_pkg::WORD_W-1:0]    sec_r, sec_nxt;
  logic [crs_pkg::WORD_W-1:0]    ns_r, ns_nxt;
  logic [crs_pkg::WORD_W-1:0]    sub_r, sub_nxt;
  logic [crs_pkg::WORD_W-1:0]    inc_r, inc_nxt;
  logic [crs_pkg::WORD_W-1:0]    adj_r, adj_nxt;
  logic                          slave_en_r;
  logic [crs_pkg::TICKS_W-1:0]   timeout_r;

  logic                          wait_en;
  crs_pkg::state_t               wait_to;
  logic [crs_pkg::TICKS_W-1:0]   cnt_dec;

  assign cnt_dec = cnt_r - 16'd1;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    done_nxt  = done_r;
    cnt_nxt   = cnt_r;
    sec_nxt   = sec_r;
    ns_nxt    = ns_r;
    sub_nxt   = sub_r;
    inc_nxt   = inc_r;
    adj_nxt   = adj_r;
    res       = '0;
    wait_en   = 1'b0;
    wait_to   = crs_pkg::ST_IDLE;

    if (fire) begin
      case (item.command)
        crs_pkg::CMD_TICK: begin
          if (slave_en_r) begin
            case (state_r)
              crs_pkg::ST_IDLE: begin
                if (pend_r != crs_pkg::ACT_NONE) begin
                  cnt_nxt   = timeout_r;
                  state_nxt = crs_pkg::ST_WR_SEC;
                end
              end
              crs_pkg::ST_WR_SEC: begin
                if (pend_r == crs_pkg::ACT_HARD_SYNC) begin
                  done_nxt              = 1'b0;
                  state_nxt             = crs_pkg::ST_WT_SEC;
                  res.valid             = 1'b1;
                  res.data.kind         = crs_pkg::KIND_WRITE;
                  res.data.target       = crs_pkg::TGT_SEC;
                  res.data.write_value  = sec_r;
                end else begin
                  state_nxt = crs_pkg::ST_WR_PPS;
                end
              end
              crs_pkg::ST_WT_SEC: begin
                wait_en = 1'b1;
                wait_to = crs_pkg::ST_WR_NS;
              end
              crs_pkg::ST_WR_NS: begin
                done_nxt             = 1'b0;
                cnt_nxt              = timeout_r;
                state_nxt            = crs_pkg::ST_WT_NS;
                res.valid            = 1'b1;
                res.data.kind        = crs_pkg::KIND_WRITE;
                res.data.target      = crs_pkg::TGT_NS;
                res.data.write_value = ns_r;
              end
              crs_pkg::ST_WT_NS: begin
                wait_en = 1'b1;
                wait_to = crs_pkg::ST_DONE;
              end
              crs_pkg::ST_WR_PPS: begin
                if (pend_r == crs_pkg::ACT_PPS) begin
                  done_nxt             = 1'b0;
                  cnt_nxt              = timeout_r;
                  state_nxt            = crs_pkg::ST_WT_PPS;
                  res.valid            = 1'b1;
                  res.data.kind        = crs_pkg::KIND_WRITE;
                  res.data.target      = crs_pkg::TGT_PPS;
                  res.data.write_value = crs_pkg::PPS_ENABLE_WORD;
                end else begin
                  state_nxt = crs_pkg::ST_WR_SUB;
                end
              end
              crs_pkg::ST_WT_PPS: begin
                wait_en = 1'b1;
                wait_to = crs_pkg::ST_DONE;
              end
              crs_pkg::ST_WR_SUB: begin
                if (pend_r == crs_pkg::ACT_INC) begin
                  done_nxt             = 1'b0;
                  cnt_nxt              = timeout_r;
                  state_nxt            = crs_pkg::ST_WT_SUB;
                  res.valid            = 1'b1;
                  res.data.kind        = crs_pkg::KIND_WRITE;
                  res.data.target      = crs_pkg::TGT_SUBINC;
                  res.data.write_value = sub_r;
                end else begin
                  state_nxt = crs_pkg::ST_WR_ADJ;
                end
              end
              crs_pkg::ST_WT_SUB: begin
                wait_en = 1'b1;
                wait_to = crs_pkg::ST_WR_INC;
              end
              crs_pkg::ST_WR_INC: begin
                done_nxt             = 1'b0;
                cnt_nxt              = timeout_r;
                state_nxt            = crs_pkg::ST_WT_INC;
                res.valid            = 1'b1;
                res.data.kind        = crs_pkg::KIND_WRITE;
                res.data.target      = crs_pkg::TGT_INC;
                res.data.write_value = inc_r;
              end
              crs_pkg::ST_WT_INC: begin
                wait_en = 1'b1;
                wait_to = crs_pkg::ST_DONE;
              end
              crs_pkg::ST_WR_ADJ: begin
                if (pend_r == crs_pkg::ACT_ADJUST) begin
                  done_nxt             = 1'b0;
                  cnt_nxt              = timeout_r;
                  state_nxt            = crs_pkg::ST_WT_ADJ;
                  res.valid            = 1'b1;
                  res.data.kind        = crs_pkg::KIND_WRITE;
                  res.data.target      = crs_pkg::TGT_ADJ;
                  res.data.write_value = adj_r;
                end else begin
                  state_nxt = crs_pkg::ST_DONE;
                end
              end
              crs_pkg::ST_WT_ADJ: begin
                wait_en = 1'b1;
                wait_to = crs_pkg::ST_DONE;
              end
              crs_pkg::ST_DONE: begin
                state_nxt     = crs_pkg::ST_IDLE;
                pend_nxt      = crs_pkg::ACT_NONE;
                res.valid     = 1'b1;
                res.data.kind = crs_pkg::KIND_DONE;
              end
              default: begin
                state_nxt = crs_pkg::ST_IDLE;
                pend_nxt  = crs_pkg::ACT_NONE;
              end
            endcase

            if (wait_en) begin
              if (done_r) begin
                cnt_nxt   = timeout_r;
                state_nxt = wait_to;
              end else begin
                cnt_nxt = cnt_dec;
                if (cnt_dec == '0) begin
                  state_nxt     = crs_pkg::ST_IDLE;
                  pend_nxt      = crs_pkg::ACT_NONE;
                  res.valid     = 1'b1;
                  res.data.kind = crs_pkg::KIND_TIMEOUT;
                end
              end
            end
          end
        end
        crs_pkg::CMD_REQ: begin
          if (item.action <= crs_pkg::ACT_ADJUST) begin
            pend_nxt = item.action;
            case (item.action)
              crs_pkg::ACT_HARD_SYNC: begin
                sec_nxt = item.value_a;
                ns_nxt  = item.value_b;
              end
              crs_pkg::ACT_INC: begin
                inc_nxt = item.value_a;
                sub_nxt = item.value_b;
              end
              crs_pkg::ACT_ADJUST: begin
                adj_nxt = item.value_a;
              end
              default: begin
              end
            endcase
          end
        end
        crs_pkg::CMD_OK: begin
          done_nxt = 1'b1;
        end
        default: begin
          state_nxt     = crs_pkg::ST_IDLE;
          pend_nxt      = crs_pkg::ACT_NONE;
          res.valid     = 1'b1;
          res.data.kind = crs_pkg::KIND_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crs_pkg::ST_IDLE;
      pend_r  <= crs_pkg::ACT_NONE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      sec_r   <= '0;
      ns_r    <= '0;
      sub_r   <= '0;
      inc_r   <= '0;
      adj_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      sec_r   <= sec_nxt;
      ns_r    <= ns_nxt;
      sub_r   <= sub_nxt;
      inc_r   <= inc_nxt;
      adj_r   <= adj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_en_r <= 1'b0;
      timeout_r  <= crs_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        crs_pkg::CFG_SLAVE_EN: slave_en_r <= cfg_data[0];
        crs_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crs_out_stage.sv =====
// result register; takes a new result whenever the slot is empty or draining
`default_nettype none
module crs_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire crs_pkg::res_msg_t res,
  output      logic              can_take,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      crs_pkg::result_t  out_data
);

  logic              v_r, v_nxt;
  crs_pkg::result_t  data_r;

  assign can_take  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = data_r;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = res.valid;
    end else if (out_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data_r <= res.data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/clock_register_write_sequencer.sv =====
// top level of the clock register write sequencer
//
//   channel  | direction | handshake        | payload
//   in_ch    | sink      | valid / ready    | command, action, value_a, value_b
//   out_ch   | source    | valid / ready    | kind, target, write_value
//   cfg_*    | sink      | cfg_we only      | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_ch.ready is high; a transaction is
// held in the input register, is decoded against the sequencer state and any
// result it gives lands in the result register
// reset is synchronous and active low; no clearing pass
// a stalled result holds the result register; one more transaction may wait in
// the input register, after which in_ch.ready drops
`default_nettype none
module clock_register_write_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  crs_item_if.sink                           in_ch,
  crs_result_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crs_pkg::TICKS_W-1:0]   cfg_data
);

  crs_pkg::item_t    in_item;
  crs_pkg::item_t    held_item;
  logic              held_valid;
  logic              can_take;
  logic              fire;
  logic              in_ready;
  logic              out_valid;
  crs_pkg::res_msg_t res;
  crs_pkg::result_t  out_data;

  assign in_item.command = in_ch.command;
  assign in_item.action  = in_ch.action;
  assign in_item.value_a = in_ch.value_a;
  assign in_item.value_b = in_ch.value_b;
  assign in_ch.ready     = in_ready;

  assign fire = held_valid && can_take;

  crs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  crs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (held_item),
    .res       (res)
  );

  crs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_data.kind;
  assign out_ch.target      = out_data.target;
  assign out_ch.write_value = out_data.write_value;

endmodule
`default_nettype wire

// ===== rtl/crs_checker.sv =====
// port-level checks on the sequencer result channel, bound to the top level
`default_nettype none
module crs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [2:0]  out_target,
  input wire logic [31:0] out_write_value
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_target)
      && $stable(out_write_value))
    else $error("result payload changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != crs_pkg::KIND_WRITE |->
      out_target == 3'd0 && out_write_value == '0)
    else $error("status result carries a target or value");

  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == crs_pkg::KIND_WRITE |-> out_target <= crs_pkg::TGT_ADJ)
    else $error("register write to an unknown target");

  a_pps_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == crs_pkg::KIND_WRITE && out_target == crs_pkg::TGT_PPS
      |-> out_write_value == crs_pkg::PPS_ENABLE_WORD)
    else $error("pps control write with a wrong word");

endmodule

bind clock_register_write_sequencer crs_checker u_crs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_target      (out_ch.target),
  .out_write_value (out_ch.write_value)
);
`default_nettype wire

// ===== bench/clock_register_write_sequencer_tb.sv =====
// self-checking testbench of the clock register write sequencer
`timescale 1ns / 1ps
module clock_register_write_sequencer_tb;
  import crs_pkg::*;

  class write_seq_scoreboard;
    bit                slave_en;
    logic [15:0]       timeout_ticks;
    state_t            st;
    act_t              pending;
    bit                done_flag;
    logic [15:0]       wait_cnt;
    logic [31:0]       sec_w, ns_w, subinc_w, inc_w, adj_w;
    result_t           expected_q[$];
    int                errors;
    int                items_seen;
    int                kind_seen[4];

    function new();
      slave_en      = 1'b0;
      timeout_ticks = TIMEOUT_RESET;
      st            = ST_IDLE;
      pending       = ACT_NONE;
      done_flag     = 1'b0;
      wait_cnt      = '0;
      sec_w         = '0;
      ns_w          = '0;
      subinc_w      = '0;
      inc_w         = '0;
      adj_w         = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      if (idx == CFG_SLAVE_EN) slave_en = v[0];
      else timeout_ticks = v;
    endfunction

    function void push(kind_t k, tgt_t t, logic [31:0] v);
      result_t r;
      r.kind        = k;
      r.target      = t;
      r.write_value = v;
      expected_q.push_back(r);
    endfunction

    function void end_sequence();
      st      = ST_IDLE;
      pending = ACT_NONE;
    endfunction

    function void issue_write(state_t nxt, tgt_t t, logic [31:0] v);
      done_flag = 1'b0;
      wait_cnt  = timeout_ticks;
      st        = nxt;
      push(KIND_WRITE, t, v);
    endfunction

    function void await_write(state_t nxt);
      if (done_flag) begin
        wait_cnt = timeout_ticks;
        st       = nxt;
      end else begin
        wait_cnt = wait_cnt - 16'd1;
        if (wait_cnt == 16'd0) begin
          end_sequence();
          push(KIND_TIMEOUT, TGT_SEC, '0);
        end
      end
    endfunction

    function void note_item(item_t it);
      items_seen++;
      case (cmd_t'(it.command))
        CMD_TICK: begin
          if (slave_en) begin
            case (st)
              ST_IDLE: begin
                if (pending != ACT_NONE) begin
                  wait_cnt = timeout_ticks;
                  st       = ST_WR_SEC;
                end
              end
              ST_WR_SEC: begin
                if (pending == ACT_HARD_SYNC) begin
                  done_flag = 1'b0;
                  st        = ST_WT_SEC;
                  push(KIND_WRITE, TGT_SEC, sec_w);
                end else st = ST_WR_PPS;
              end
              ST_WT_SEC: await_write(ST_WR_NS);
              ST_WR_NS:  issue_write(ST_WT_NS, TGT_NS, ns_w);
              ST_WT_NS:  await_write(ST_DONE);
              ST_WR_PPS: begin
                if (pending == ACT_PPS) issue_write(ST_WT_PPS, TGT_PPS, PPS_ENABLE_WORD);
                else st = ST_WR_SUB;
              end
              ST_WT_PPS: await_write(ST_DONE);
              ST_WR_SUB: begin
                if (pending == ACT_INC) issue_write(ST_WT_SUB, TGT_SUBINC, subinc_w);
                else st = ST_WR_ADJ;
              end
              ST_WT_SUB: await_write(ST_WR_INC);
              ST_WR_INC: issue_write(ST_WT_INC, TGT_INC, inc_w);
              ST_WT_INC: await_write(ST_DONE);
              ST_WR_ADJ: begin
                if (pending == ACT_ADJUST) issue_write(ST_WT_ADJ, TGT_ADJ, adj_w);
                else st = ST_DONE;
              end
              ST_WT_ADJ: await_write(ST_DONE);
              ST_DONE: begin
                end_sequence();
                push(KIND_DONE, TGT_SEC, '0);
              end
              default: end_sequence();
            endcase
          end
        end
        CMD_REQ: begin
          if (it.action <= ACT_ADJUST) begin
            pending = act_t'(it.action);
            case (pending)
              ACT_HARD_SYNC: begin
                sec_w = it.value_a;
                ns_w  = it.value_b;
              end
              ACT_INC: begin
                inc_w    = it.value_a;
                subinc_w = it.value_b;
              end
              ACT_ADJUST: adj_w = it.value_a;
              default: ;
            endcase
          end
        end
        CMD_OK: done_flag = 1'b1;
        default: begin
          end_sequence();
          push(KIND_FAIL, TGT_SEC, '0);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %0d target %0d value %h",
                 $time, got.kind, got.target, got.write_value);
        return;
      end
      exp = expected_q.pop_front();
      kind_seen[got.kind]++;
      if (got.kind !== exp.kind) begin
        errors++;
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, exp.kind, got.kind);
      end
      if (got.target !== exp.target) begin
        errors++;
        $display("%0t: target mismatch, expected %0d actual %0d", $time, exp.target,
                 got.target);
      end
      if (got.write_value !== exp.write_value) begin
        errors++;
        $display("%0t: write_value mismatch, expected %h actual %h", $time,
                 exp.write_value, got.write_value);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICKS_W-1:0]   cfg_data;
  bit                   gaps_en;
  bit                   stall_en;
  int                   settings_written;

  write_seq_scoreboard sb = new();

  crs_item_if   in_ch();
  crs_result_if out_ch();

  clock_register_write_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= !(stall_en && $urandom_range(0, 99) < 13);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(result_t'{out_ch.kind, out_ch.target, out_ch.write_value});
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed sequences that follow the predicted state, with some noise
  function automatic item_t make_item();
    item_t       it;
    int unsigned r;
    r          = $urandom_range(0, 99);
    it.value_a = rand_word();
    it.value_b = rand_word();
    it.action  = 3'($urandom_range(0, 7));
    it.command = CMD_TICK;
    if (r < 3) it.command = CMD_FAIL;
    else if (r < 7) it.command = CMD_REQ;
    else if (r < 10) it.command = CMD_OK;
    else if (sb.st == ST_IDLE && sb.pending == ACT_NONE) begin
      it.command = CMD_REQ;
      it.action  = 3'($urandom_range(ACT_HARD_SYNC, ACT_ADJUST));
    end else if (sb.st inside {ST_WT_SEC, ST_WT_NS, ST_WT_PPS, ST_WT_SUB, ST_WT_INC,
                               ST_WT_ADJ} && !sb.done_flag && $urandom_range(0, 2) == 0) begin
      it.command = CMD_OK;
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk);
    while (gaps_en && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= it.command;
    in_ch.action  <= it.action;
    in_ch.value_a <= it.value_a;
    in_ch.value_b <= it.value_b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  task automatic send(cmd_t c, logic [2:0] a, logic [31:0] va, logic [31:0] vb);
    send_item(item_t'{c, a, va, vb});
  endtask

  task automatic tick(int n);
    repeat (n) send(CMD_TICK, ACT_NONE, $urandom, $urandom);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    settings_written++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_for_results();
      send_item(make_item());
    end
    wait_for_results();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = '0;
    in_ch.action  = '0;
    in_ch.value_a = '0;
    in_ch.value_b = '0;
    out_ch.ready  = 1'b0;
    gaps_en       = 1'b1;
    stall_en      = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_SLAVE_EN, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd3);

    // hard sync through both writes to the finish report
    tick(1);
    send(CMD_OK, ACT_NONE, '0, '0);
    send(CMD_REQ, ACT_HARD_SYNC, 32'hFFFF_FFFF, 32'h0000_0000);
    tick(2);
    send(CMD_OK, ACT_NONE, '0, '0);
    tick(2);
    send(CMD_OK, ACT_NONE, '0, '0);
    tick(2);
    // pps write left to time out
    send(CMD_REQ, ACT_PPS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tick(6);
    // request replaced mid-sequence, then a failure abort
    send(CMD_REQ, ACT_INC, 32'h0000_0000, 32'hFFFF_FFFF);
    tick(1);
    send(CMD_REQ, ACT_ADJUST, 32'h5A5A_A5A5, 32'h1234_5678);
    tick(4);
    send(CMD_FAIL, ACT_NONE, '0, '0);
    send(CMD_REQ, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_results();

    gaps_en  = 1'b0;
    stall_en = 1'b0;
    write_reg(CFG_TIMEOUT, 16'd1);
    run_random(200);

    gaps_en  = 1'b1;
    stall_en = 1'b1;
    write_reg(CFG_TIMEOUT, 16'd8);
    run_random(450);

    write_reg(CFG_SLAVE_EN, 16'd0);
    run_random(60);

    write_reg(CFG_SLAVE_EN, 16'd1);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    run_random(300);

    write_reg(CFG_TIMEOUT, 16'd2);
    run_random(350);

    write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
    run_random(250);

    $display("%0d input transactions across %0d register writes", sb.items_seen,
             settings_written);
    $display("checked %0d writes, %0d finishes, %0d timeouts, %0d failure aborts",
             sb.kind_seen[KIND_WRITE], sb.kind_seen[KIND_DONE], sb.kind_seen[KIND_TIMEOUT],
             sb.kind_seen[KIND_FAIL]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== clock_register_write_sequencer.f =====
rtl/crs_pkg.sv
rtl/crs_if.sv
rtl/crs_in_stage.sv
rtl/crs_core.sv
rtl/crs_out_stage.sv
rtl/clock_register_write_sequencer.sv
rtl/crs_checker.sv
bench/clock_register_write_sequencer_tb.sv
